[hdl/nrc_pkg.sv]
package nrc_pkg;

	// Result kinds carried on out_kind
	localparam logic [1:0] KIND_DIGIT    = 2'd0;
	localparam logic [1:0] KIND_EMPTY    = 2'd1;
	localparam logic [1:0] KIND_BADCHAR  = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_SOURCE_BASE = 2'd0;
	localparam logic [1:0] REG_TARGET_BASE = 2'd1;
	localparam logic [1:0] REG_PAD_WIDTH   = 2'd2;

	localparam logic [5:0] BASE_MIN   = 6'd2;
	localparam logic [5:0] BASE_MAX   = 6'd36;
	localparam logic [5:0] BASE_RESET = 6'd10;
	localparam logic [6:0] NOT_DIGIT  = 7'd64;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [7:0] ASCII_A    = 8'h41;
	localparam logic [7:0] ASCII_Z    = 8'h5A;

	// Status of the shared divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Digit value of an ASCII character, NOT_DIGIT if it is none
	function automatic logic [6:0] char_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
			v = c - ASCII_ZERO;
			return v[6:0];
		end
		if (c >= ASCII_A && c <= ASCII_Z) begin
			v = c - ASCII_A + 8'd10;
			return v[6:0];
		end
		return NOT_DIGIT;
	endfunction

	// ASCII glyph of a digit value 0..35
	function automatic logic [7:0] glyph(input logic [5:0] dv);
		if (dv < 6'd10) begin
			return ASCII_ZERO + {2'b00, dv};
		end
		return ASCII_A - 8'd10 + {2'b00, dv};
	endfunction

	// Clamp a radix to 2..36
	function automatic logic [5:0] clamp_base(input logic [5:0] b);
		if (b < BASE_MIN) begin
			return BASE_MIN;
		end
		if (b > BASE_MAX) begin
			return BASE_MAX;
		end
		return b;
	endfunction

endpackage

[hdl/nrc_divider.sv]
module nrc_divider import nrc_pkg::*; #(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [5:0]            divisor,
	output div_stat_t             stat,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [5:0]            remainder
);

	localparam int STEP_W = $clog2(VALUE_BITS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_BITS - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [5:0]            rem_q;
	logic [5:0]            divisor_q;

	logic [6:0] trial;
	logic [6:0] diff;
	logic       ge;
	logic [5:0] rem_next;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, quo_q[VALUE_BITS-1]};
		diff     = trial - {1'b0, divisor_q};
		ge       = trial >= {1'b0, divisor_q};
		rem_next = ge ? diff[5:0] : trial[5:0];
	end

	// Sequence the steps, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			step_q    <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			divisor_q <= BASE_MIN;
		end else if (start) begin
			busy_q    <= 1'b1;
			done_q    <= 1'b0;
			step_q    <= '0;
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= rem_next;
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < divisor_q)
		else $error("divider remainder not below divisor");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

endmodule

[hdl/numeral_radix_converter.sv]
// Radix converter for ASCII numerals. Characters ('0'-'9', 'A'-'Z') enter one
// beat at a time, most significant first, in source_base; on the beat marked
// in_last the value goes out as ASCII digits in target_base, most significant
// first, padded with '0' to pad_width digits, or as one marker beat of kind
// empty, invalid character or overflow. in_ready is high only while idle. A
// character that is not last is accepted, then folded in by a multiply-add.
// The last character is followed by a status check, after which an invalid
// character or overflow marker is shown at once. Otherwise each digit of the
// value comes from the shared bit-serial divider, which yields one quotient
// bit a cycle while busy; a zero value yields no digits. The output is then
// sized, and each digit beat passes through buffer read, output load and
// handoff, which waits on out_ready; an empty marker goes straight to handoff.
module numeral_radix_converter import nrc_pkg::*; #(
	parameter int VALUE_BITS = 31,
	parameter int MAX_PAD    = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_en,
	input  logic [1:0] cfg_addr,
	input  logic [6:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic [1:0] out_kind,
	output logic       out_last
);

	localparam int PROD_W  = VALUE_BITS + 6;
	localparam int DCNT_W  = $clog2(VALUE_BITS + 1);
	localparam int IDX_W   = $clog2(VALUE_BITS);
	localparam int TOT_MAX = (MAX_PAD > VALUE_BITS) ? MAX_PAD : VALUE_BITS;
	localparam int TOT_W   = $clog2(TOT_MAX + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FOLD,
		ST_CHECK,
		ST_DSTART,
		ST_DWAIT,
		ST_TOTAL,
		ST_FETCH,
		ST_LOAD,
		ST_SHOW
	} state_t;

	state_t                state_q;
	logic [5:0]            source_base_q;
	logic [5:0]            target_base_q;
	logic [6:0]            pad_width_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic                  bad_q;
	logic                  ovf_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic [TOT_W-1:0]      left_q;
	logic                  out_valid_q;
	logic [7:0]            out_char_q;
	logic [1:0]            out_kind_q;
	logic                  out_last_q;
	logic [5:0]            rd_q;

	logic [5:0] digit_mem [VALUE_BITS];

	logic [5:0]            sb;
	logic [5:0]            tb;
	logic [6:0]            dval;
	logic                  char_bad;
	logic [PROD_W-1:0]     prod;
	logic                  prod_ovf;
	logic [TOT_W-1:0]      pad_eff;
	logic [TOT_W-1:0]      dcnt_ext;
	logic [TOT_W-1:0]      total;
	logic [IDX_W-1:0]      rd_addr;
	logic [IDX_W-1:0]      wr_addr;
	logic                  wr_en;
	logic                  div_start;
	div_stat_t             div_stat;
	logic [VALUE_BITS-1:0] div_quo;
	logic [5:0]            div_rem;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_base_q <= BASE_RESET;
			target_base_q <= BASE_RESET;
			pad_width_q   <= '0;
		end else if (cfg_en) begin
			case (cfg_addr)
				REG_SOURCE_BASE: source_base_q <= cfg_data[5:0];
				REG_TARGET_BASE: target_base_q <= cfg_data[5:0];
				REG_PAD_WIDTH:   pad_width_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode the held character and form the multiply-add
	always_comb begin
		sb       = clamp_base(source_base_q);
		tb       = clamp_base(target_base_q);
		dval     = char_value(char_q);
		char_bad = dval >= {1'b0, sb};
		prod     = PROD_W'(acc_q) * PROD_W'(sb) + PROD_W'(dval[5:0]);
		prod_ovf = |prod[PROD_W-1:VALUE_BITS];
	end

	// Count of result beats: digits or pad, whichever is larger
	always_comb begin
		pad_eff  = (pad_width_q > 7'(MAX_PAD)) ? TOT_W'(MAX_PAD) : TOT_W'(pad_width_q);
		dcnt_ext = TOT_W'(dcnt_q);
		total    = (dcnt_ext > pad_eff) ? dcnt_ext : pad_eff;
		rd_addr  = IDX_W'(left_q - TOT_W'(1));
		wr_addr  = IDX_W'(dcnt_q);
		wr_en    = (state_q == ST_DWAIT) && div_stat.done;
		div_start = (state_q == ST_DSTART) && (acc_q != '0);
	end

	nrc_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (tb),
		.stat     (div_stat),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Digit buffer, least significant digit at index zero
	always_ff @(posedge clk) begin
		if (wr_en) begin
			digit_mem[wr_addr] <= div_rem;
		end
		rd_q <= digit_mem[rd_addr];
	end

	// Sequence fold, conversion and output beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			char_q      <= '0;
			last_q      <= 1'b0;
			acc_q       <= '0;
			bad_q       <= 1'b0;
			ovf_q       <= 1'b0;
			dcnt_q      <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_kind_q  <= KIND_DIGIT;
			out_last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						char_q  <= in_char;
						last_q  <= in_last;
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					if (char_bad) begin
						bad_q <= 1'b1;
					end else if (!bad_q && !ovf_q) begin
						if (prod_ovf) begin
							ovf_q <= 1'b1;
						end else begin
							acc_q <= prod[VALUE_BITS-1:0];
						end
					end
					state_q <= last_q ? ST_CHECK : ST_IDLE;
				end
				ST_CHECK: begin
					if (bad_q || ovf_q) begin
						out_char_q  <= '0;
						out_kind_q  <= bad_q ? KIND_BADCHAR : KIND_OVERFLOW;
						out_last_q  <= 1'b1;
						out_valid_q <= 1'b1;
						left_q      <= TOT_W'(1);
						state_q     <= ST_SHOW;
					end else begin
						state_q <= ST_DSTART;
					end
				end
				ST_DSTART: begin
					state_q <= (acc_q == '0) ? ST_TOTAL : ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_stat.done) begin
						acc_q   <= div_quo;
						dcnt_q  <= dcnt_q + 1'b1;
						state_q <= (div_quo == '0) ? ST_TOTAL : ST_DSTART;
					end
				end
				ST_TOTAL: begin
					if (total == '0) begin
						out_char_q  <= '0;
						out_kind_q  <= KIND_EMPTY;
						out_last_q  <= 1'b1;
						out_valid_q <= 1'b1;
						left_q      <= TOT_W'(1);
						state_q     <= ST_SHOW;
					end else begin
						left_q  <= total;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					out_char_q  <= (left_q > dcnt_ext) ? ASCII_ZERO : glyph(rd_q);
					out_kind_q  <= KIND_DIGIT;
					out_last_q  <= (left_q == TOT_W'(1));
					out_valid_q <= 1'b1;
					state_q     <= ST_SHOW;
				end
				ST_SHOW: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							acc_q   <= '0;
							bad_q   <= 1'b0;
							ovf_q   <= 1'b0;
							dcnt_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							left_q  <= left_q - 1'b1;
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;

	a_no_input_while_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ready)
		else $error("input taken while a result is pending");

	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q != KIND_DIGIT) |-> (out_char_q == '0 && out_last_q))
		else $error("marker beat with char or without last");

	a_digit_fits_buffer: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> dcnt_q < DCNT_W'(VALUE_BITS))
		else $error("digit buffer overrun");

	a_last_on_final_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_DIGIT) |-> (out_last_q == (left_q == TOT_W'(1))))
		else $error("last flag does not match remaining beat count");

endmodule
